/* rtl/core/brmd_pkg.sv */
`default_nettype none
package brmd_pkg;

  // Field widths of the bus item and of the result item.
  localparam int AddrWidth = 16;
  localparam int DataWidth = 8;
  localparam int BankWidth = 7;
  localparam int OffsetWidth = 13;
  localparam int RomAddrWidth = BankWidth + OffsetWidth;
  localparam int NumWindows = 4;

  // Bus access kinds.
  localparam logic OP_READ = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Bank register addresses.
  localparam logic [AddrWidth-1:0] BANK0_ADDR = 16'h5000;
  localparam logic [AddrWidth-1:0] BANK1_ADDR = 16'h5400;
  localparam logic [AddrWidth-1:0] BANK2_ADDR = 16'h5800;
  localparam logic [AddrWidth-1:0] BANK3_ADDR = 16'h5C00;

  // Window range and values returned on the data bus.
  localparam logic [AddrWidth-1:0] WIN_LOW = 16'h4000;
  localparam logic [AddrWidth-1:0] WIN_END = 16'hC000;
  localparam logic [DataWidth-1:0] XOR_KEY = 8'h4D;
  localparam logic [DataWidth-1:0] OPEN_BUS = 8'hFF;

  typedef logic [BankWidth-1:0] bank_t;

  // Fixed bit permutation followed by the key XOR.
  function automatic logic [DataWidth-1:0] descramble(input logic [DataWidth-1:0] d);
    logic [DataWidth-1:0] q;
    q = {d[6], d[2], d[4], d[0], d[1], d[5], d[7], d[3]};
    return q ^ XOR_KEY;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/banked_rom_mapper_descrambler.sv */
// An item accepted into the input register passes on to the result register, from which it
// leaves when out_ready is high. The decode, bank select and permutation sit in one stage.
// Throughput: one item per cycle while the result side is not stalled.
// A stalled result does not block intake until the input register is also occupied.
// Reset (rst, synchronous, active high) clears all bank registers to zero, turns
// descrambling off, clears entry_address and empties both pipeline registers.
`default_nettype none
module banked_rom_mapper_descrambler
  import brmd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    operation,
  input  wire logic [AddrWidth-1:0]    bus_address,
  input  wire logic [DataWidth-1:0]    write_data,
  input  wire logic [DataWidth-1:0]    rom_byte,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [DataWidth-1:0]         read_data,
  output logic [RomAddrWidth-1:0]      rom_address,
  output logic                         window_hit,
  input  wire logic                    cfg_we,
  input  wire logic [AddrWidth-1:0]    cfg_wdata
);

  logic [AddrWidth-1:0] entry_address;

  // Input register.
  logic                 s1_valid;
  logic                 s1_op;
  logic [AddrWidth-1:0] s1_addr;
  logic [DataWidth-1:0] s1_wdata;
  logic [DataWidth-1:0] s1_rbyte;

  // Mapper state.
  bank_t bank_select [NumWindows];
  logic  descramble_on;

  logic s1_advance;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_advance;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_address <= '0;
    end else if (cfg_we) begin
      entry_address <= cfg_wdata;
    end
  end

  // Capture the bus item.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_op    <= operation;
      s1_addr  <= bus_address;
      s1_wdata <= write_data;
      s1_rbyte <= rom_byte;
    end
  end

  // Address decode and data path for the item in the input register.
  logic                       in_window;
  logic [2:0]                 win_raw;
  logic [1:0]                 win;
  logic [DataWidth-1:0]       read_data_next;
  logic [RomAddrWidth-1:0]    rom_address_next;
  logic                       window_hit_next;
  logic                       descramble_on_next;

  assign win_raw = s1_addr[AddrWidth-1:OffsetWidth] - WIN_LOW[AddrWidth-1:OffsetWidth];
  assign win = win_raw[1:0];
  assign in_window = (s1_addr >= WIN_LOW) && (s1_addr < WIN_END);

  always_comb begin
    read_data_next     = '0;
    rom_address_next   = '0;
    window_hit_next    = 1'b0;
    descramble_on_next = descramble_on;
    if (s1_op == OP_READ) begin
      if (!in_window) begin
        read_data_next = OPEN_BUS;
      end else begin
        rom_address_next = {bank_select[win], s1_addr[OffsetWidth-1:0]};
        window_hit_next  = 1'b1;
        if (descramble_on) begin
          read_data_next = descramble(s1_rbyte);
        end else begin
          read_data_next = s1_rbyte;
          if (s1_addr == entry_address) begin
            descramble_on_next = 1'b1;
          end
        end
      end
    end
  end

  // State update happens as the item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      descramble_on <= 1'b0;
      for (int i = 0; i < NumWindows; i++) begin
        bank_select[i] <= '0;
      end
    end else if (s1_advance) begin
      descramble_on <= descramble_on_next;
      if (s1_op == OP_WRITE) begin
        case (s1_addr)
          BANK0_ADDR: bank_select[0] <= s1_wdata[BankWidth-1:0];
          BANK1_ADDR: bank_select[1] <= s1_wdata[BankWidth-1:0];
          BANK2_ADDR: bank_select[2] <= s1_wdata[BankWidth-1:0];
          BANK3_ADDR: bank_select[3] <= s1_wdata[BankWidth-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      read_data   <= read_data_next;
      rom_address <= rom_address_next;
      window_hit  <= window_hit_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/brmd_checker.sv */
`default_nettype none
module brmd_checker
  import brmd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [DataWidth-1:0]    read_data,
  input wire logic [RomAddrWidth-1:0] rom_address,
  input wire logic                    window_hit
);

  // The output comes up empty after reset.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds its fields.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) &&
      $stable(rom_address) && $stable(window_hit))
    else $error("stalled result changed");

  // Outside the windows no ROM address is reported.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_hit |-> rom_address == '0)
    else $error("rom address set without a window hit");

  // Without a window hit the data is either open bus or the write result.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !window_hit |-> (read_data == OPEN_BUS) || (read_data == '0))
    else $error("unexpected data without a window hit");

endmodule

bind banked_rom_mapper_descrambler brmd_checker u_brmd_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .read_data   (read_data),
  .rom_address (rom_address),
  .window_hit  (window_hit)
);
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import brmd_pkg::*;

  localparam int ClkHalfNs = 6;
  localparam int RunLimitNs = 10_000_000;
  localparam int DrainCycles = 10;

  // One result item as the block presents it.
  typedef struct packed {
    logic [DataWidth-1:0]    data;
    logic [RomAddrWidth-1:0] addr;
    logic                    hit;
  } bus_result_t;

  // Tracks the mapper state and holds the expected result of every accepted item.
  class mapper_scoreboard;
    bank_t                bank_of_window[NumWindows];
    bit                   scramble_on;
    logic [AddrWidth-1:0] entry;
    bus_result_t          expected_q[$];
    int                   errors;

    function new();
      for (int i = 0; i < NumWindows; i++) bank_of_window[i] = '0;
      scramble_on = 1'b0;
      entry = '0;
      errors = 0;
    endfunction

    function void set_entry(logic [AddrWidth-1:0] value);
      entry = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Bit shuffle of the data bus, then the key.
    function logic [DataWidth-1:0] unscramble(logic [DataWidth-1:0] d);
      logic [DataWidth-1:0] q;
      q[0] = d[3];
      q[1] = d[7];
      q[2] = d[5];
      q[3] = d[1];
      q[4] = d[0];
      q[5] = d[4];
      q[6] = d[2];
      q[7] = d[6];
      return q ^ XOR_KEY;
    endfunction

    function void note_input(logic op, logic [AddrWidth-1:0] addr,
                             logic [DataWidth-1:0] wdata, logic [DataWidth-1:0] rbyte);
      bus_result_t          res;
      logic [AddrWidth-1:0] offset;
      logic [1:0]           win;
      res = '0;
      if (op == OP_WRITE) begin
        // Only the four bank register addresses have an effect.
        case (addr)
          BANK0_ADDR: bank_of_window[0] = wdata[BankWidth-1:0];
          BANK1_ADDR: bank_of_window[1] = wdata[BankWidth-1:0];
          BANK2_ADDR: bank_of_window[2] = wdata[BankWidth-1:0];
          BANK3_ADDR: bank_of_window[3] = wdata[BankWidth-1:0];
          default: ;
        endcase
      end else if (addr < WIN_LOW || addr >= WIN_END) begin
        res.data = OPEN_BUS;
      end else begin
        offset = addr - WIN_LOW;
        win = offset[14:13];
        res.addr = {bank_of_window[win], addr[OffsetWidth-1:0]};
        res.hit = 1'b1;
        if (scramble_on) begin
          res.data = unscramble(rbyte);
        end else begin
          // The entry read itself still returns the raw byte.
          res.data = rbyte;
          if (addr == entry) scramble_on = 1'b1;
        end
      end
      expected_q.push_back(res);
    endfunction

    task report(string field, longint unsigned actual, longint unsigned wanted);
      $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $time, field, actual, wanted);
      errors++;
    endtask

    task check_result(logic [DataWidth-1:0] data, logic [RomAddrWidth-1:0] addr, logic hit);
      bus_result_t wanted;
      if (expected_q.size() == 0) begin
        report("unexpected result, read_data", data, 0);
      end else begin
        wanted = expected_q.pop_front();
        if (data !== wanted.data) report("read_data", data, wanted.data);
        if (addr !== wanted.addr) report("rom_address", addr, wanted.addr);
        if (hit !== wanted.hit) report("window_hit", hit, wanted.hit);
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    operation;
  logic [AddrWidth-1:0]    bus_address;
  logic [DataWidth-1:0]    write_data;
  logic [DataWidth-1:0]    rom_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [DataWidth-1:0]    read_data;
  logic [RomAddrWidth-1:0] rom_address;
  logic                    window_hit;
  logic                    cfg_we;
  logic [AddrWidth-1:0]    cfg_wdata;

  mapper_scoreboard sb;
  bit send_burst;
  bit recv_burst;

  banked_rom_mapper_descrambler u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .bus_address (bus_address),
    .write_data  (write_data),
    .rom_byte    (rom_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_data   (read_data),
    .rom_address (rom_address),
    .window_hit  (window_hit),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #(ClkHalfNs) clk = ~clk;
  end

  // Idle length for the next item; runs of back-to-back items come and go at random.
  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 23) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 16);
  endfunction

  // Addresses at the window and bank boundaries.
  function automatic logic [AddrWidth-1:0] boundary_addr(int idx);
    case (idx)
      0: return 16'h0000;
      1: return 16'h3FFF;
      2: return 16'h4000;
      3: return 16'h5FFF;
      4: return 16'h6000;
      5: return 16'h7FFF;
      6: return 16'h8000;
      7: return 16'h9FFF;
      8: return 16'hA000;
      9: return 16'hBFFF;
      10: return 16'hC000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Offers one bus item and waits until it is accepted. Valid stays high afterwards
  // so that a following item with no gap goes out on the next cycle.
  task automatic send_item(logic op, logic [AddrWidth-1:0] addr,
                           logic [DataWidth-1:0] wdata, logic [DataWidth-1:0] rbyte);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    bus_address <= addr;
    write_data <= wdata;
    rom_byte <= rbyte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(op, addr, wdata, rbyte);
  endtask

  // Stops the input side and waits until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes the entry address while the block is idle.
  task automatic write_entry(logic [AddrWidth-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_entry(value);
  endtask

  // One random bus access, weighted toward bank setup and window reads.
  task automatic send_random_item();
    int                   kind;
    logic                 op;
    logic [AddrWidth-1:0] addr;
    logic [1:0]           bank_idx;
    kind = $urandom_range(0, 99);
    op = OP_READ;
    addr = 16'($urandom_range(0, 16'hFFFF));
    if (kind < 15) begin
      op = OP_WRITE;
      bank_idx = 2'($urandom_range(0, 3));
      case (bank_idx)
        2'd0: addr = BANK0_ADDR;
        2'd1: addr = BANK1_ADDR;
        2'd2: addr = BANK2_ADDR;
        default: addr = BANK3_ADDR;
      endcase
    end else if (kind < 22) begin
      // Writes into the bank register range above BANK0_ADDR, or to any other address.
      op = OP_WRITE;
      if ($urandom_range(0, 1) == 1) addr = BANK0_ADDR + 16'($urandom_range(1, 16'h0FFF));
    end else if (kind < 62) begin
      addr = WIN_LOW + 16'($urandom_range(0, 16'h7FFF));
    end else if (kind < 72) begin
      if ($urandom_range(0, 1) == 1) addr = 16'($urandom_range(0, 16'h3FFF));
      else addr = WIN_END + 16'($urandom_range(0, 16'h3FFF));
    end else if (kind < 82) begin
      op = 1'($urandom_range(0, 1));
      addr = boundary_addr(int'($urandom_range(0, 11)));
    end else if (kind < 85) begin
      op = 1'($urandom_range(0, 1));
      addr = sb.entry;
    end else begin
      op = 1'($urandom_range(0, 1));
    end
    send_item(op, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(logic [AddrWidth-1:0] entry_value, int count);
    drain();
    write_entry(entry_value);
    repeat (count) send_random_item();
  endtask

  // Result side: stalls at random and checks each accepted result.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(read_data, rom_address, window_hit);
    end
  end

  // Stimulus and end of test.
  initial begin
    sb = new();
    send_burst = 1'b0;
    recv_burst = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_READ;
    bus_address = '0;
    write_data = '0;
    rom_byte = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with the entry address at zero, outside the windows.
    write_entry(16'h0000);
    send_item(OP_WRITE, BANK0_ADDR, 8'hFF, 8'h00);
    send_item(OP_WRITE, BANK1_ADDR, 8'h80, 8'hFF);
    send_item(OP_WRITE, BANK2_ADDR, 8'h55, 8'h00);
    send_item(OP_WRITE, BANK3_ADDR, 8'h2A, 8'h00);
    send_item(OP_WRITE, 16'h5001, 8'h11, 8'h00);
    send_item(OP_WRITE, 16'h5BFF, 8'h22, 8'h00);
    send_item(OP_WRITE, 16'h4000, 8'h33, 8'h00);
    send_item(OP_READ, 16'h4000, 8'h00, 8'h00);
    send_item(OP_READ, 16'h5FFF, 8'h00, 8'hFF);
    send_item(OP_READ, 16'h6000, 8'h00, 8'hA5);
    send_item(OP_READ, 16'h9FFF, 8'h00, 8'h5A);
    send_item(OP_READ, 16'hA000, 8'h00, 8'h01);
    send_item(OP_READ, 16'hBFFF, 8'h00, 8'h80);
    send_item(OP_READ, 16'h3FFF, 8'h34, 8'h12);
    send_item(OP_READ, 16'hC000, 8'h00, 8'hFF);
    send_item(OP_READ, 16'h0000, 8'h00, 8'h77);
    send_item(OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
    send_item(OP_WRITE, BANK3_ADDR, 8'h7F, 8'h00);
    send_item(OP_READ, 16'hBFFF, 8'hFF, 8'h3C);
    send_item(OP_WRITE, 16'hFFFF, 8'hFF, 8'hFF);

    // Entry address outside the windows: data stays raw throughout.
    run_phase(16'hFFFF, 300);

    // Entry at the bottom of the windows; a random hit may latch descrambling.
    run_phase(16'h4000, 250);
    // If descrambling is not yet on, the entry read returns raw data and the next one is descrambled.
    send_item(OP_READ, 16'h4000, 8'h00, 8'h96);
    send_item(OP_READ, 16'h4000, 8'h00, 8'h96);
    send_item(OP_READ, 16'h4001, 8'h00, 8'h00);
    send_item(OP_READ, 16'h4002, 8'h00, 8'hFF);

    run_phase(16'hBFFF, 400);
    run_phase(WIN_LOW + 16'($urandom_range(0, 16'h7FFF)), 430);

    drain();
    if (sb.errors == 0) begin
      $display("[banked_rom_mapper_descrambler] OK");
    end else begin
      $display("[banked_rom_mapper_descrambler] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(RunLimitNs);
    $display("[banked_rom_mapper_descrambler] ERROR");
    $finish;
  end

endmodule
